>>> rtl/bact_pkg.sv
// ----------------------------------------------------------------------------
// bact_pkg: types and codes for the bump allocator with chunk tables
// Request and result beat layouts, status codes and field widths.
// ----------------------------------------------------------------------------
package bact_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned SizeW = 17;
  localparam int unsigned StatW = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_ZERO     = 3'd1;
  localparam logic [StatW-1:0] ST_OOM      = 3'd2;
  localparam logic [StatW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [StatW-1:0] ST_NULL     = 3'd5;

  typedef struct packed {
    logic             func;
    logic [SizeW-1:0] req_size;
    logic [AddrW-1:0] addr;
    logic             addr_null;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] out_addr;
    logic             out_null;
    logic [SizeW-1:0] chunk_size;
    logic [StatW-1:0] status;
  } rsp_t;

  // one table entry: start address and length
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] len;
  } entry_t;

endpackage

>>> rtl/bact_table.sv
// ----------------------------------------------------------------------------
// bact_table: address-sorted chunk table
// Entry memory, one read and one write port, with a count; the sequencer drives
// reads and writes one entry per cycle. Read data is registered.
// ----------------------------------------------------------------------------
module bact_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [$clog2(DEPTH)-1:0]   rd_idx,
  output bact_pkg::entry_t           rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_idx,
  input  bact_pkg::entry_t           wr_data,
  input  logic                       cnt_inc,
  input  logic                       cnt_dec,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  bact_pkg::entry_t mem [DEPTH];
  logic [$clog2(DEPTH+1)-1:0] count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cnt_inc) begin
      count_r <= count_r + 1'b1;
    end else if (cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  assign count = count_r;

endmodule

>>> rtl/bump_allocator_chunk_tables_top.sv
// ----------------------------------------------------------------------------
// bump_allocator_chunk_tables_top: bump allocator with sorted chunk tables
// Requests arrive as in_ beats (allocate or free) and each yields exactly one
// out_ beat carrying address, null flag, chunk size and status.
// The heap limit is written through the cfg_ channel while the block is idle.
//
// Timing: one request is in flight at a time; in_ready is low meanwhile.
// A request rejected at decode goes from S_DECIDE straight to S_OUT. A
// successful allocate appends to the used table (the bump pointer only grows,
// so no entry moves) and passes through S_INS_RD and S_INS_CMP to S_OUT. A free
// scans the used table entry by entry up to the hit (S_SCAN_RD, S_SCAN_CMP; not
// found or freed table full goes to S_OUT), shifts the freed table on insert
// (S_FINS_RD, S_FINS_CMP per entry moved) and closes the gap in the used table
// (S_REM_RD, S_REM_WR per entry moved). Each table is read and written through
// its own read and write ports, one entry at a time.
// The result sits in an output register until out_ready; the next request is
// taken in the cycle after delivery.
// Reset (synchronous, rst_n low) clears the bump pointer and both counts and
// sets the limit to 65536; table contents need no clearing.
// ----------------------------------------------------------------------------
module bump_allocator_chunk_tables_top #(
  parameter int unsigned HEAP_BYTES  = 65536,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bact_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bact_pkg::rsp_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bact_pkg::SizeW-1:0]  cfg_data
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [bact_pkg::SizeW:0] HeapC = (bact_pkg::SizeW+1)'(HEAP_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_INS_RD, S_INS_CMP, S_SCAN_RD, S_SCAN_CMP,
    S_FINS_RD, S_FINS_CMP, S_REM_RD, S_REM_WR, S_OUT
  } state_t;

  state_t state_r;
  bact_pkg::req_t req_r;
  bact_pkg::rsp_t rsp_r;
  logic [bact_pkg::SizeW-1:0] limit_r, bump_r;
  logic [IdxW-1:0] idx_r;          // index being read / shifted
  logic [CntW-1:0] pos_r;          // scan position (may reach count)
  logic [CntW-1:0] hit_r;          // used-table position of the freed chunk
  bact_pkg::entry_t ent_r;         // entry being moved / inserted

  // used table
  logic [IdxW-1:0] u_rd_idx, u_wr_idx;
  bact_pkg::entry_t u_rd, u_wr;
  logic u_we, u_inc, u_dec;
  logic [CntW-1:0] u_cnt;
  // freed table
  logic [IdxW-1:0] f_rd_idx, f_wr_idx;
  bact_pkg::entry_t f_rd, f_wr;
  logic f_we, f_inc;
  logic [CntW-1:0] f_cnt;

  function automatic bact_pkg::rsp_t err_rsp(logic [bact_pkg::StatW-1:0] st);
    bact_pkg::rsp_t r;
    r = '{out_addr: '0, out_null: 1'b1, chunk_size: '0, status: st};
    return r;
  endfunction

  bact_table #(.DEPTH(TABLE_DEPTH)) u_used (
    .clk, .rst_n, .rd_idx(u_rd_idx), .rd_data(u_rd), .wr_en(u_we),
    .wr_idx(u_wr_idx), .wr_data(u_wr), .cnt_inc(u_inc), .cnt_dec(u_dec),
    .count(u_cnt)
  );

  bact_table #(.DEPTH(TABLE_DEPTH)) u_freed (
    .clk, .rst_n, .rd_idx(f_rd_idx), .rd_data(f_rd), .wr_en(f_we),
    .wr_idx(f_wr_idx), .wr_data(f_wr), .cnt_inc(f_inc), .cnt_dec(1'b0),
    .count(f_cnt)
  );

  // heap-limit compare for allocate
  logic [bact_pkg::SizeW:0] sum_w, lim_w;
  logic oom_w;
  assign sum_w = {1'b0, bump_r} + {1'b0, req_r.req_size};
  assign lim_w = ({1'b0, limit_r} < HeapC) ? {1'b0, limit_r} : HeapC;
  assign oom_w = sum_w > lim_w;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = rsp_r;

  // table port control, decoded from state
  always_comb begin
    u_rd_idx = idx_r;
    f_rd_idx = idx_r;
    u_wr_idx = idx_r;
    f_wr_idx = idx_r;
    u_wr = ent_r;
    f_wr = ent_r;
    u_we = 1'b0;
    f_we = 1'b0;
    u_inc = 1'b0;
    u_dec = 1'b0;
    f_inc = 1'b0;
    case (state_r)
      S_SCAN_RD: u_rd_idx = pos_r[IdxW-1:0];
      S_INS_CMP: begin
        // shift up while new start is below the entry read
        u_we = 1'b1;
        if (pos_r != '0 && ent_r.start < u_rd.start) begin
          u_wr_idx = pos_r[IdxW-1:0];
          u_wr = u_rd;
        end else begin
          u_wr_idx = pos_r[IdxW-1:0];
          u_inc = 1'b1;
        end
      end
      S_FINS_CMP: begin
        f_we = 1'b1;
        f_wr_idx = pos_r[IdxW-1:0];
        if (pos_r != '0 && ent_r.start < f_rd.start) begin
          f_wr = f_rd;
        end else begin
          f_inc = 1'b1;
        end
      end
      S_REM_WR: begin
        u_we = 1'b1;
        u_wr_idx = pos_r[IdxW-1:0];
        u_wr = u_rd;
      end
      S_REM_RD: begin
        u_rd_idx = IdxW'(pos_r + 1'b1);
        if (pos_r + 1'b1 >= u_cnt) begin
          u_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= bact_pkg::SizeW'(65536);
      bump_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            limit_r <= cfg_data;
          end
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (req_r.func == bact_pkg::FUNC_ALLOC) begin
            if (req_r.req_size == '0) begin
              rsp_r <= err_rsp(bact_pkg::ST_ZERO);
              state_r <= S_OUT;
            end else if (oom_w) begin
              rsp_r <= err_rsp(bact_pkg::ST_OOM);
              state_r <= S_OUT;
            end else if (u_cnt >= DepthC) begin
              rsp_r <= err_rsp(bact_pkg::ST_FULL);
              state_r <= S_OUT;
            end else begin
              rsp_r <= '{out_addr: bump_r[bact_pkg::AddrW-1:0], out_null: 1'b0,
                         chunk_size: req_r.req_size, status: bact_pkg::ST_OK};
              bump_r <= sum_w[bact_pkg::SizeW-1:0];
              ent_r  <= '{start: bump_r[bact_pkg::AddrW-1:0], len: req_r.req_size};
              pos_r  <= u_cnt;
              idx_r  <= IdxW'(u_cnt - 1'b1);
              state_r <= S_INS_RD;
            end
          end else if (req_r.addr_null) begin
            rsp_r <= err_rsp(bact_pkg::ST_NULL);
            state_r <= S_OUT;
          end else begin
            rsp_r <= err_rsp(bact_pkg::ST_OK);
            pos_r <= '0;
            state_r <= S_SCAN_RD;
          end
        end
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (pos_r != '0 && ent_r.start < u_rd.start) begin
            pos_r <= pos_r - 1'b1;
            idx_r <= IdxW'(pos_r - 2'd2);
            state_r <= S_INS_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SCAN_RD: begin
          if (pos_r >= u_cnt) begin
            rsp_r.status <= bact_pkg::ST_NOTFOUND;
            state_r <= S_OUT;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (u_rd.start == req_r.addr) begin
            if (f_cnt >= DepthC) begin
              rsp_r.status <= bact_pkg::ST_FULL;
              state_r <= S_OUT;
            end else begin
              rsp_r.chunk_size <= u_rd.len;
              ent_r <= u_rd;
              hit_r <= pos_r;
              pos_r <= f_cnt;
              idx_r <= IdxW'(f_cnt - 1'b1);
              state_r <= S_FINS_RD;
            end
          end else begin
            pos_r <= pos_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_FINS_RD: state_r <= S_FINS_CMP;
        S_FINS_CMP: begin
          if (pos_r != '0 && ent_r.start < f_rd.start) begin
            pos_r <= pos_r - 1'b1;
            idx_r <= IdxW'(pos_r - 2'd2);
            state_r <= S_FINS_RD;
          end else begin
            pos_r <= hit_r;
            state_r <= S_REM_RD;
          end
        end
        S_REM_RD: begin
          if (pos_r + 1'b1 >= u_cnt) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          pos_r <= pos_r + 1'b1;
          state_r <= S_REM_RD;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bact_checker.sv
// ----------------------------------------------------------------------------
// bact_checker: port-level checks for the allocator
// Watches handshakes and result codes on the top level ports.
// ----------------------------------------------------------------------------
module bact_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bact_pkg::rsp_t out_data
);

  // no new request while a result beat waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready with result pending");

  // a result never appears the cycle after acceptance
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

  // only a good allocate returns an address
  a_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_null) |-> out_data.status == bact_pkg::ST_OK)
    else $error("address with error status");

endmodule

bind bump_allocator_chunk_tables_top bact_checker u_bact_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

>>> test/bump_allocator_chunk_tables_top_test.sv
// ----------------------------------------------------------------------------
// bump_allocator_chunk_tables_top_test: self-checking bench for the allocator
// Drives allocate and free beats and shadows the bump pointer and both sorted
// chunk tables to predict every result beat. Frees are mostly aimed at live
// chunks so that both tables fill. The heap limit is changed between phases,
// and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module bump_allocator_chunk_tables_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP  = 65536;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned WDOG  = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bact_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bact_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bact_pkg::SizeW-1:0] cfg_data = '0;

  bump_allocator_chunk_tables_top #(.HEAP_BYTES(HEAP), .TABLE_DEPTH(DEPTH)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the allocator
  logic [bact_pkg::SizeW-1:0] heap_lim;
  int unsigned      bump;
  bact_pkg::entry_t used_tab [DEPTH];
  bact_pkg::entry_t freed_tab [DEPTH];
  int unsigned      used_cnt, freed_cnt;

  bact_pkg::req_t req_q [$];
  bact_pkg::rsp_t rsp_q [$];
  int   mode;          // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit   hold_req;
  int   hold_cnt;
  bit   in_taken, cfg_taken;
  int   errors, quiet, n_rsp, n_ok_alloc, n_ok_free, n_full;

  function automatic void tab_insert(ref bact_pkg::entry_t tab [DEPTH],
                                     ref int unsigned cnt,
                                     input bact_pkg::entry_t e);
    int unsigned i;
    i = cnt;
    while (i > 0 && e.start < tab[i-1].start) begin
      tab[i] = tab[i-1];
      i--;
    end
    tab[i] = e;
    cnt++;
  endfunction

  function automatic bact_pkg::rsp_t allocator_step(bact_pkg::req_t r);
    bact_pkg::rsp_t   o;
    int unsigned      lim, i, pos;
    bit               hit;
    bact_pkg::entry_t e;
    o = '0;
    o.out_null = 1'b1;
    o.status = bact_pkg::ST_OK;
    lim = (heap_lim < HEAP) ? heap_lim : HEAP;
    if (r.func == bact_pkg::FUNC_ALLOC) begin
      if (r.req_size == 0) o.status = bact_pkg::ST_ZERO;
      else if (bump + r.req_size > lim) o.status = bact_pkg::ST_OOM;
      else if (used_cnt >= DEPTH) o.status = bact_pkg::ST_FULL;
      else begin
        e.start = bump[bact_pkg::AddrW-1:0];
        e.len = r.req_size;
        tab_insert(used_tab, used_cnt, e);
        o.out_addr = bump[bact_pkg::AddrW-1:0];
        o.out_null = 1'b0;
        o.chunk_size = r.req_size;
        bump += r.req_size;
      end
    end else if (r.addr_null) begin
      o.status = bact_pkg::ST_NULL;
    end else begin
      hit = 1'b0;
      pos = 0;
      for (i = 0; i < used_cnt; i++)
        if (!hit && used_tab[i].start == r.addr) begin
          hit = 1'b1;
          pos = i;
        end
      if (!hit) o.status = bact_pkg::ST_NOTFOUND;
      else if (freed_cnt >= DEPTH) o.status = bact_pkg::ST_FULL;
      else begin
        e = used_tab[pos];
        tab_insert(freed_tab, freed_cnt, e);
        for (i = pos; i + 1 < used_cnt; i++) used_tab[i] = used_tab[i+1];
        used_cnt--;
        o.chunk_size = e.len;
      end
    end
    return o;
  endfunction

  // monitor: predict on accepted requests, check on accepted results
  always @(posedge clk) begin
    bact_pkg::rsp_t exp_r;
    if (!rst_n) begin
      heap_lim = bact_pkg::SizeW'(HEAP);
      bump = 0;
      used_cnt = 0;
      freed_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        heap_lim = cfg_data;
        cfg_taken = 1'b1;
      end
      if (in_valid && in_ready) begin
        rsp_q.push_back(allocator_step(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        n_rsp++;
        if (rsp_q.size() == 0) begin
          $error("unexpected result beat %p", out_data);
          errors++;
        end else begin
          exp_r = rsp_q.pop_front();
          if (out_data.status == bact_pkg::ST_OK && !out_data.out_null) n_ok_alloc++;
          if (out_data.status == bact_pkg::ST_OK && out_data.out_null) n_ok_free++;
          if (out_data.status == bact_pkg::ST_FULL) n_full++;
          if (out_data.out_addr !== exp_r.out_addr) begin
            $error("out_addr exp %0h got %0h", exp_r.out_addr, out_data.out_addr);
            errors++;
          end
          if (out_data.out_null !== exp_r.out_null) begin
            $error("out_null exp %0b got %0b", exp_r.out_null, out_data.out_null);
            errors++;
          end
          if (out_data.chunk_size !== exp_r.chunk_size) begin
            $error("chunk_size exp %0d got %0d", exp_r.chunk_size, out_data.chunk_size);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_data.status);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WDOG) begin
        $display("[bump_allocator_chunk_tables_top] ERROR");
        $finish;
      end
    end
  end

  // driver: hold the beat until taken, then pop the next or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (req_q.size() != 0 &&
          !((mode == 1 && $urandom_range(99) < 49) || (mode == 3 && $urandom_range(99) < 15)))
      begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a long hold-off when asked, else random stalls per mode
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else if ((mode == 2 && $urandom_range(99) < 49) || (mode == 3 && $urandom_range(99) < 15))
      out_ready <= 1'b0;
    else
      out_ready <= 1'b1;
  end

  function automatic bact_pkg::req_t mk_req(logic f, int unsigned sz, int unsigned a,
                                            logic nul);
    bact_pkg::req_t r;
    r.func = f;
    r.req_size = sz[bact_pkg::SizeW-1:0];
    r.addr = a[bact_pkg::AddrW-1:0];
    r.addr_null = nul;
    return r;
  endfunction

  function automatic bact_pkg::req_t rand_req();
    int unsigned k, lim;
    bact_pkg::req_t r;
    k = $urandom_range(99);
    lim = (heap_lim < HEAP) ? heap_lim : HEAP;
    r = mk_req(bact_pkg::FUNC_ALLOC, $urandom_range(1, 256), $urandom_range(65535),
               1'($urandom_range(1)));
    if (k < 55) begin
      // small allocate, already set
    end else if (k < 60) r.req_size = bact_pkg::SizeW'($urandom_range(65536));
    else if (k < 63) r.req_size = '0;
    else if (k < 66) r.req_size = (lim > bump) ? bact_pkg::SizeW'(lim - bump)
                                               : bact_pkg::SizeW'($urandom_range(1, 65536));
    else begin
      r.func = bact_pkg::FUNC_FREE;
      r.req_size = bact_pkg::SizeW'($urandom_range(65536));
      r.addr_null = 1'b0;
      if (k < 88 && used_cnt > 0) r.addr = used_tab[$urandom_range(used_cnt - 1)].start;
      else if (k >= 94) r.addr_null = 1'b1;
    end
    return r;
  endfunction

  task automatic drain();
    while (req_q.size() != 0 || in_valid || rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    drain();
    @(negedge clk);
    cfg_taken = 1'b0;
    cfg_data <= v[bact_pkg::SizeW-1:0];
    cfg_valid <= 1'b1;
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int m, int n);
    mode = m;
    repeat (n) begin
      while (req_q.size() != 0) @(posedge clk);
      req_q.push_back(rand_req());
    end
  endtask

  initial begin
    mode = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_limit(HEAP);
    // directed: zero size, null frees, unknown address, bad sizes, allocates, frees
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 0, 16'hFFFF, 1'b1));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 1, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 65536, 16'hFFFF, 1'b1));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 0, 1'b1));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 16'hFFFF, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 65536, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 7, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 100, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 3, 0, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 8, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_FREE, 0, 1, 1'b0));
    req_q.push_back(mk_req(bact_pkg::FUNC_ALLOC, 65535, 0, 1'b0));
    run_phase(0, 180);

    set_limit(bump + $urandom_range(2000, 8000));
    hold_req = 1'b1;
    run_phase(1, 180);

    set_limit(1);
    run_phase(2, 60);

    set_limit(HEAP);
    run_phase(3, 230);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d results: %0d allocations, %0d frees, %0d table-full rejections",
             n_rsp, n_ok_alloc, n_ok_free, n_full);
    $display("heap used up to %0d bytes across four limits and four idle patterns", bump);
    if (errors == 0 && rsp_q.size() == 0)
      $display("[bump_allocator_chunk_tables_top] OK");
    else
      $display("[bump_allocator_chunk_tables_top] ERROR");
    $finish;
  end
endmodule

>>> sim.f
rtl/bact_pkg.sv
rtl/bact_table.sv
rtl/bump_allocator_chunk_tables_top.sv
rtl/bact_checker.sv
test/bump_allocator_chunk_tables_top_test.sv
